FILE: rtl/ansi_sgr_stream_attribute_decoder_unit_defines.svh
// Assertion macros for the decoder RTL, used by the result queue.
// Depends on nothing; users provide clk and arst_n in scope.
`ifndef ANSI_SGR_STREAM_ATTRIBUTE_DECODER_UNIT_DEFINES_SVH
`define ANSI_SGR_STREAM_ATTRIBUTE_DECODER_UNIT_DEFINES_SVH

// Checked property that is ignored while reset is asserted.
`define ASDU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define ASDU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/asdu_pkg.sv
// Types, constants and color functions of the SGR attribute decoder.
// Used by asdu_core, asdu_outq and the top level; depends on nothing.
package asdu_pkg;

	// Escape parser modes.
	typedef enum logic [2:0] {
		M_TEXT    = 3'd0,
		M_ESC     = 3'd1,
		M_CSI     = 3'd2,
		M_OSC     = 3'd3,
		M_OSCESC  = 3'd4,
		M_CHARSET = 3'd5
	} mode_t;

	// Result actions.
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DEFAULT_FG = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_BG = 2'd1;

	localparam logic [23:0] RST_DEFAULT_FG = 24'hD8FFE4;
	localparam logic [23:0] RST_DEFAULT_BG = 24'h06121F;

	// Control characters.
	localparam logic [15:0] CH_BEL = 16'h0007;
	localparam logic [15:0] CH_BS  = 16'h0008;
	localparam logic [15:0] CH_TAB = 16'h0009;
	localparam logic [15:0] CH_LF  = 16'h000A;
	localparam logic [15:0] CH_CR  = 16'h000D;
	localparam logic [15:0] CH_ESC = 16'h001B;

	localparam logic [23:0] PAL_NORM [8] = '{
		24'h4D4D4D, 24'hF14C4C, 24'h23D18B, 24'hF5F543,
		24'h3B8EEA, 24'hD670D6, 24'h29B8DB, 24'hE5E5E5
	};
	localparam logic [23:0] PAL_BRIGHT [8] = '{
		24'h666666, 24'hFF6B6B, 24'h50FA7B, 24'hFFF56D,
		24'h69B4FF, 24'hFF79FF, 24'h6EFFFF, 24'hFFFFFF
	};

	typedef struct packed {
		logic [23:0] fg;
		logic [23:0] bg;
		logic        bgdef;
		logic        bold;
		logic        ul;
	} attr_t;

	// Pending extended color sequence (38/48 ; 5|2 ; ...).
	typedef struct packed {
		logic [2:0] cnt;
		logic       head_fg;
		logic       is5;
		logic [9:0] b2;
		logic [9:0] b3;
	} ext_t;

	typedef struct packed {
		ext_t  e;
		attr_t a;
	} push_res_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] ch;
		logic [23:0] fg;
		logic [23:0] bg;
		logic        bgdef;
		logic        bold;
		logic        ul;
		logic        last;
	} res_t;

	// Cube step to channel level.
	function automatic logic [7:0] cube_level(input logic [2:0] x);
		logic [7:0] v;
		v = (x == 3'd0) ? 8'd0 : 8'(8'd55 + 8'(x) * 8'd40);
		return v;
	endfunction

	// 256-color index to RGB; indexes above 255 clamp.
	function automatic logic [23:0] color256(input logic [9:0] iw);
		logic [7:0]  i;
		logic [7:0]  c;
		logic [15:0] p6;
		logic [5:0]  q6;
		logic [10:0] p36;
		logic [2:0]  r;
		logic [2:0]  g;
		logic [2:0]  b;
		logic [7:0]  gv;
		logic [23:0] rgb;
		i   = (iw > 10'd255) ? 8'd255 : iw[7:0];
		c   = i - 8'd16;
		// Divide by 6 and by 36 through reciprocal multiplies.
		p6  = 16'(c) * 16'd171;
		q6  = p6[15:10];
		p36 = 11'(q6) * 11'd43;
		r   = p36[10:8];
		g   = 3'(q6 - 6'(r) * 6'd6);
		b   = 3'(c - 8'(q6) * 8'd6);
		gv  = 8'(8'd8 + 8'(i - 8'd232) * 8'd10);
		if (i < 8'd8) begin
			rgb = PAL_NORM[i[2:0]];
		end else if (i < 8'd16) begin
			rgb = PAL_BRIGHT[i[2:0]];
		end else if (i < 8'd232) begin
			rgb = {cube_level(r), cube_level(g), cube_level(b)};
		end else begin
			rgb = {gv, gv, gv};
		end
		return rgb;
	endfunction

	function automatic logic [7:0] sat255(input logic [9:0] v);
		logic [7:0] s;
		s = (v > 10'd255) ? 8'd255 : v[7:0];
		return s;
	endfunction

	function automatic attr_t set_color(input attr_t a, input logic head_fg,
			input logic [23:0] rgb);
		attr_t o;
		o = a;
		if (head_fg) begin
			o.fg = rgb;
		end else begin
			o.bg    = rgb;
			o.bgdef = 1'b0;
		end
		return o;
	endfunction

	// One plain SGR code applied to an attribute set.
	function automatic attr_t apply_code(input attr_t a, input logic [9:0] v,
			input logic [23:0] dfg, input logic [23:0] dbg);
		attr_t      o;
		logic [9:0] d30;
		logic [9:0] d90;
		logic [9:0] d40;
		logic [9:0] d100;
		o    = a;
		d30  = v - 10'd30;
		d90  = v - 10'd90;
		d40  = v - 10'd40;
		d100 = v - 10'd100;
		if (v == 10'd0) begin
			o = '{fg: dfg, bg: dbg, bgdef: 1'b1, bold: 1'b0, ul: 1'b0};
		end else if (v == 10'd1) begin
			o.bold = 1'b1;
		end else if (v == 10'd4) begin
			o.ul = 1'b1;
		end else if (v == 10'd22) begin
			o.bold = 1'b0;
		end else if (v == 10'd24) begin
			o.ul = 1'b0;
		end else if (v == 10'd39) begin
			o.fg = dfg;
		end else if (v == 10'd49) begin
			o.bg    = dbg;
			o.bgdef = 1'b1;
		end else if (v >= 10'd30 && v <= 10'd37) begin
			o.fg = a.bold ? PAL_BRIGHT[d30[2:0]] : PAL_NORM[d30[2:0]];
		end else if (v >= 10'd90 && v <= 10'd97) begin
			o.fg = PAL_BRIGHT[d90[2:0]];
		end else if (v >= 10'd40 && v <= 10'd47) begin
			o.bg    = PAL_NORM[d40[2:0]];
			o.bgdef = 1'b0;
		end else if (v >= 10'd100 && v <= 10'd107) begin
			o.bg    = PAL_BRIGHT[d100[2:0]];
			o.bgdef = 1'b0;
		end
		return o;
	endfunction

	// One finished parameter pushed through the extended color tracker.
	function automatic push_res_t push_param(input ext_t e, input attr_t a,
			input logic [9:0] v, input logic [23:0] dfg, input logic [23:0] dbg);
		push_res_t o;
		logic      is_ext;
		o.e    = e;
		o.a    = a;
		is_ext = (v == 10'd38) || (v == 10'd48);
		unique case (e.cnt)
			3'd0: begin
				if (is_ext) begin
					o.e.head_fg = (v == 10'd38);
					o.e.cnt     = 3'd1;
				end else begin
					o.a = apply_code(a, v, dfg, dbg);
				end
			end
			3'd1: begin
				if (v == 10'd5 || v == 10'd2) begin
					o.e.is5 = (v == 10'd5);
					o.e.cnt = 3'd2;
				end else if (is_ext) begin
					o.e.head_fg = (v == 10'd38);
					o.e.cnt     = 3'd1;
				end else begin
					o.e.cnt = 3'd0;
					o.a     = apply_code(a, v, dfg, dbg);
				end
			end
			3'd2: begin
				if (e.is5) begin
					o.a     = set_color(a, e.head_fg, color256(v));
					o.e.cnt = 3'd0;
				end else begin
					o.e.b2  = v;
					o.e.cnt = 3'd3;
				end
			end
			3'd3: begin
				o.e.b3  = v;
				o.e.cnt = 3'd4;
			end
			default: begin
				o.a     = set_color(a, e.head_fg,
					{sat255(e.b2), sat255(e.b3), sat255(v)});
				o.e.cnt = 3'd0;
			end
		endcase
		return o;
	endfunction

endpackage

FILE: rtl/asdu_core.sv
// Escape parser and attribute state of the SGR decoder; one code unit per step.
// Depends on asdu_pkg.
module asdu_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [15:0]         ch,
	input  logic                eot,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [23:0]         cfg_wdata,
	output logic                res_a_vld,
	output asdu_pkg::res_t      res_a,
	output logic                res_b_vld,
	output asdu_pkg::res_t      res_b
);

	asdu_pkg::mode_t mode_q, n_mode;
	asdu_pkg::attr_t cur_q, n_cur;
	asdu_pkg::attr_t sh_q, n_sh;
	asdu_pkg::ext_t  ext_q, n_ext;
	logic [9:0]      acc_q, n_acc;
	logic            bad_q, n_bad;
	logic            pcr_q, n_pcr;
	logic            at_start_q, n_at_start;
	logic [23:0]     dfg_q, dbg_q;

	asdu_pkg::push_res_t pr;
	asdu_pkg::attr_t     fl;
	asdu_pkg::attr_t     cur_d;
	logic [9:0]          pval;
	logic [13:0]         prod;
	logic                as_eff;

	// Next state and results for the code unit in the input register.
	always_comb begin
		n_mode     = mode_q;
		n_cur      = cur_q;
		n_sh       = sh_q;
		n_ext      = ext_q;
		n_acc      = acc_q;
		n_bad      = bad_q;
		n_pcr      = 1'b0;
		n_at_start = 1'b0;
		pval       = bad_q ? 10'd0 : acc_q;
		pr         = asdu_pkg::push_param(ext_q, sh_q, pval, dfg_q, dbg_q);
		fl         = pr.a;
		prod       = 14'(acc_q) * 14'd10 + 14'(ch[3:0]);

		res_a_vld     = pcr_q && (ch != asdu_pkg::CH_LF);
		res_a         = '0;
		res_a.action  = asdu_pkg::ACT_CLEAR;
		res_b_vld     = 1'b0;
		res_b         = '0;
		res_b.action  = asdu_pkg::ACT_INSERT;
		res_b.last    = 1'b1;

		unique case (mode_q)
			asdu_pkg::M_ESC: begin
				if (ch == 16'h005B) begin
					n_mode = asdu_pkg::M_CSI;
					n_acc  = '0;
					n_bad  = 1'b0;
					n_ext.cnt = 3'd0;
					n_sh   = cur_q;
				end else if (ch == 16'h005D) begin
					n_mode = asdu_pkg::M_OSC;
				end else if (ch == 16'h0028 || ch == 16'h0029 || ch == 16'h0023
						|| ch == 16'h0025) begin
					n_mode = asdu_pkg::M_CHARSET;
				end else begin
					n_mode = asdu_pkg::M_TEXT;
				end
			end
			asdu_pkg::M_CHARSET: begin
				n_mode = asdu_pkg::M_TEXT;
			end
			asdu_pkg::M_OSC: begin
				if (ch == asdu_pkg::CH_BEL) begin
					n_mode = asdu_pkg::M_TEXT;
				end else if (ch == asdu_pkg::CH_ESC) begin
					n_mode = asdu_pkg::M_OSCESC;
				end
			end
			asdu_pkg::M_OSCESC: begin
				if (ch == 16'h005C || ch == asdu_pkg::CH_BEL) begin
					n_mode = asdu_pkg::M_TEXT;
				end else if (ch != asdu_pkg::CH_ESC) begin
					n_mode = asdu_pkg::M_OSC;
				end
			end
			asdu_pkg::M_CSI: begin
				if (ch >= 16'h0040 && ch <= 16'h007E) begin
					// Final byte: only 'm' commits the gathered attributes.
					if (ch == 16'h006D) begin
						if (pr.e.cnt >= 3'd3) begin
							fl = asdu_pkg::apply_code(fl, pr.e.b2, dfg_q, dbg_q);
						end
						if (pr.e.cnt == 3'd4) begin
							fl = asdu_pkg::apply_code(fl, pr.e.b3, dfg_q, dbg_q);
						end
						n_cur = fl;
					end
					n_sh      = pr.a;
					n_ext     = pr.e;
					n_ext.cnt = 3'd0;
					n_acc     = '0;
					n_bad     = 1'b0;
					n_mode    = asdu_pkg::M_TEXT;
				end else if (ch >= 16'h0030 && ch <= 16'h0039) begin
					n_acc = (prod > 14'd999) ? 10'd999 : prod[9:0];
				end else if (ch == 16'h003B) begin
					n_sh  = pr.a;
					n_ext = pr.e;
					n_acc = '0;
					n_bad = 1'b0;
				end else begin
					n_bad = 1'b1;
				end
			end
			default: begin
				// Plain text, also for codes that name no mode.
				n_mode = asdu_pkg::M_TEXT;
				if (ch == asdu_pkg::CH_ESC) begin
					n_mode = asdu_pkg::M_ESC;
				end else if (ch == asdu_pkg::CH_CR) begin
					if (eot) begin
						res_b_vld    = 1'b1;
						res_b.action = asdu_pkg::ACT_CLEAR;
					end else begin
						n_pcr = 1'b1;
					end
				end else if (ch == asdu_pkg::CH_BS) begin
					res_b_vld    = 1'b1;
					res_b.action = asdu_pkg::ACT_DELETE;
				end else if (ch == asdu_pkg::CH_TAB || ch == asdu_pkg::CH_LF
						|| ch >= 16'h0020) begin
					res_b_vld   = 1'b1;
					res_b.ch    = ch;
					res_b.fg    = cur_q.fg;
					res_b.bg    = cur_q.bg;
					res_b.bgdef = cur_q.bgdef;
					res_b.bold  = cur_q.bold;
					res_b.ul    = cur_q.ul;
				end
			end
		endcase

		res_a.last = !res_b_vld;

		// End of text returns the live attributes, mode and parameter state to the defaults.
		if (eot) begin
			n_cur      = '{fg: dfg_q, bg: dbg_q, bgdef: 1'b1, bold: 1'b0, ul: 1'b0};
			n_mode     = asdu_pkg::M_TEXT;
			n_acc      = '0;
			n_bad      = 1'b0;
			n_ext      = '0;
			n_pcr      = 1'b0;
			n_at_start = 1'b1;
		end

		as_eff = step ? n_at_start : at_start_q;

		// A register write after the step reloads the live color at text start.
		cur_d = step ? n_cur : cur_q;
		if (cfg_we && cfg_idx == asdu_pkg::CFG_DEFAULT_FG && as_eff) begin
			cur_d.fg = cfg_wdata;
		end
		if (cfg_we && cfg_idx == asdu_pkg::CFG_DEFAULT_BG && as_eff) begin
			cur_d.bg = cfg_wdata;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= asdu_pkg::M_TEXT;
			cur_q      <= '{fg: asdu_pkg::RST_DEFAULT_FG, bg: asdu_pkg::RST_DEFAULT_BG,
				bgdef: 1'b1, bold: 1'b0, ul: 1'b0};
			sh_q       <= '{fg: asdu_pkg::RST_DEFAULT_FG, bg: asdu_pkg::RST_DEFAULT_BG,
				bgdef: 1'b1, bold: 1'b0, ul: 1'b0};
			ext_q      <= '0;
			acc_q      <= '0;
			bad_q      <= 1'b0;
			pcr_q      <= 1'b0;
			at_start_q <= 1'b1;
			dfg_q      <= asdu_pkg::RST_DEFAULT_FG;
			dbg_q      <= asdu_pkg::RST_DEFAULT_BG;
		end else begin
			cur_q <= cur_d;
			if (step) begin
				mode_q     <= n_mode;
				sh_q       <= n_sh;
				ext_q      <= n_ext;
				acc_q      <= n_acc;
				bad_q      <= n_bad;
				pcr_q      <= n_pcr;
				at_start_q <= n_at_start;
			end
			if (cfg_we && cfg_idx == asdu_pkg::CFG_DEFAULT_FG) begin
				dfg_q <= cfg_wdata;
			end
			if (cfg_we && cfg_idx == asdu_pkg::CFG_DEFAULT_BG) begin
				dbg_q <= cfg_wdata;
			end
		end
	end

endmodule

FILE: rtl/asdu_outq.sv
// Four-entry result queue; takes up to two results per cycle, delivers one per cycle while out_stall is low.
// Depends on asdu_pkg and the assertion macros.
`include "ansi_sgr_stream_attribute_decoder_unit_defines.svh"
module asdu_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_a,
	input  asdu_pkg::res_t res_a,
	input  logic           push_b,
	input  asdu_pkg::res_t res_b,
	input  logic           out_stall,
	output logic           room,
	output logic           out_valid,
	output asdu_pkg::res_t out_res
);

	asdu_pkg::res_t mem_q [4];
	logic [1:0]     wr_q;
	logic [1:0]     rd_q;
	logic [2:0]     cnt_q;
	logic           pop;
	logic [1:0]     push_n;

	assign out_valid = (cnt_q != 3'd0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign push_n    = 2'(push_a) + 2'(push_b);
	// Space for two more results once this cycle's beat leaves.
	assign room      = (cnt_q <= 3'd2) || (cnt_q == 3'd3 && pop);

	// Entry storage, compacted so a lone result takes the next slot.
	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_q] <= res_a;
			if (push_b) begin
				mem_q[wr_q + 2'd1] <= res_b;
			end
		end else if (push_b) begin
			mem_q[wr_q] <= res_b;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	`ASDU_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= 3'd4, "result queue count above depth")
	`ASDU_ASSERT(a_no_overflow, (push_n != 2'd0) |-> (cnt_q - 3'(pop) <= 3'd2),
		"result queue written without room")
	`ASDU_ASSERT(a_pop_only, (pop && push_n == 2'd0) |=> (cnt_q == $past(cnt_q) - 3'd1),
		"result queue count did not drop on a lone beat")

endmodule

FILE: rtl/ansi_sgr_stream_attribute_decoder_unit.sv
// ANSI SGR attribute decoder, top level: input register, decode core, result queue.
// Each accepted code unit passes the input register and then the result queue.
// Throughput: one code unit per cycle while results drain; a unit that yields two
// results (pending CR clear plus its own) queues both, and the queue delivers them in turn.
// Reset (arst_n, asynchronous, low): plain text mode, register defaults, queue empty.
module ansi_sgr_stream_attribute_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [15:0] out_char,
	output logic [23:0] fg_rgb,
	output logic [23:0] bg_rgb,
	output logic        bg_is_default,
	output logic        bold_on,
	output logic        underline_on,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic           vld_s1;
	logic [15:0]    ch_s1;
	logic           eot_s1;
	logic           room;
	logic           step;
	logic           accept;
	logic           a_vld;
	logic           b_vld;
	asdu_pkg::res_t res_a;
	asdu_pkg::res_t res_b;
	asdu_pkg::res_t out_res;

	assign cfg_ready = 1'b1;
	assign step      = vld_s1 && room;
	assign in_stall  = vld_s1 && !room;
	assign accept    = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !step);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1  <= char_code;
			eot_s1 <= end_of_text;
		end
	end

	asdu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ch        (ch_s1),
		.eot       (eot_s1),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.res_a_vld (a_vld),
		.res_a     (res_a),
		.res_b_vld (b_vld),
		.res_b     (res_b)
	);

	asdu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (step && a_vld),
		.res_a     (res_a),
		.push_b    (step && b_vld),
		.res_b     (res_b),
		.out_stall (out_stall),
		.room      (room),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign action        = out_res.action;
	assign out_char      = out_res.ch;
	assign fg_rgb        = out_res.fg;
	assign bg_rgb        = out_res.bg;
	assign bg_is_default = out_res.bgdef;
	assign bold_on       = out_res.bold;
	assign underline_on  = out_res.ul;
	assign last_of_run   = out_res.last;

endmodule
